FILE: hdl/ide_pkg.sv
// Shared types, constants and helpers for the instruction dictionary encoder.
// Used by ide_cell, ide_group and instruction_dictionary_encoder.
package ide_pkg;

    localparam int IDX_W      = 8;
    localparam int DICT_DEPTH = 1 << IDX_W;
    localparam int CNT_W      = IDX_W + 1;
    localparam int WORD_WIDTH = 64;
    localparam int LOC_W      = 4;
    localparam int GROUP_SIZE = 1 << LOC_W;
    localparam int GRP_W      = IDX_W - LOC_W;
    localparam int NUM_GROUPS = 1 << GRP_W;
    localparam int CW_W       = 4;

    localparam logic [1:0] OP_LEARN  = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_MISS  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [1:0]            op;
        logic [WORD_WIDTH-1:0] word;
        logic [IDX_W-1:0]      idx;
    } t_key;

    typedef struct packed {
        logic                  hit;
        logic [IDX_W-1:0]      idx;
        logic [WORD_WIDTH-1:0] word;
    } t_match;

    typedef struct packed {
        logic                  en;
        logic [WORD_WIDTH-1:0] word;
    } t_wr;

    function automatic logic [CW_W-1:0] width_for_count(input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] top;
        logic [CW_W-1:0]  bits;
        top  = (cnt == '0) ? '0 : cnt - CNT_W'(1);
        bits = CW_W'(1);
        for (int b = 1; b < CNT_W; b++) begin
            if (top[b]) begin
                bits = CW_W'(b + 1);
            end
        end
        return bits;
    endfunction

endpackage

FILE: hdl/ide_cell.sv
// One dictionary entry: stored word, fill flag and registered match/select bit.
// Fill order passes from the left neighbor. Depends on ide_pkg.
module ide_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_prev_valid,
    input  ide_pkg::t_wr                   i_wr,
    input  ide_pkg::t_key                  i_key,
    input  logic [ide_pkg::IDX_W-1:0]      i_cell_idx,
    output logic                           o_valid,
    output logic                           o_sel,
    output logic [ide_pkg::WORD_WIDTH-1:0] o_word
);

    logic                           r_valid;
    logic                           r_sel;
    logic [ide_pkg::WORD_WIDTH-1:0] r_word;
    logic                           n_sel;

    always_comb begin
        if (i_key.op == ide_pkg::OP_READ) begin
            n_sel = r_valid && (i_key.idx == i_cell_idx);
        end else begin
            n_sel = r_valid && (i_key.word == r_word);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            r_sel <= n_sel;
            if (i_wr.en && i_prev_valid && !r_valid) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && i_prev_valid && !r_valid) begin
            r_word <= i_wr.word;
        end
    end

    assign o_valid = r_valid;
    assign o_sel   = r_sel;
    assign o_word  = r_word;

endmodule

FILE: hdl/ide_group.sv
// A run of GROUP_SIZE cells chained by fill order, plus a registered merge of
// their selects into one match record. Depends on ide_pkg and ide_cell.
module ide_group (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_prev_valid,
    input  ide_pkg::t_wr              i_wr,
    input  ide_pkg::t_key             i_key,
    input  logic [ide_pkg::GRP_W-1:0] i_group,
    output logic                      o_last_valid,
    output ide_pkg::t_match           o_match
);

    logic [ide_pkg::GROUP_SIZE:0]     w_valid;
    logic [ide_pkg::GROUP_SIZE-1:0]   w_sel;
    logic [ide_pkg::WORD_WIDTH-1:0]   w_word [ide_pkg::GROUP_SIZE];
    ide_pkg::t_match                  n_match;
    ide_pkg::t_match                  r_match;

    assign w_valid[0] = i_prev_valid;

    for (genvar j = 0; j < ide_pkg::GROUP_SIZE; j++) begin : g_cell
        ide_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_prev_valid (w_valid[j]),
            .i_wr         (i_wr),
            .i_key        (i_key),
            .i_cell_idx   ({i_group, ide_pkg::LOC_W'(j)}),
            .o_valid      (w_valid[j+1]),
            .o_sel        (w_sel[j]),
            .o_word       (w_word[j])
        );
    end

    always_comb begin
        n_match = '0;
        for (int j = 0; j < ide_pkg::GROUP_SIZE; j++) begin
            if (w_sel[j]) begin
                n_match.hit  = 1'b1;
                n_match.idx  = n_match.idx | {i_group, ide_pkg::LOC_W'(j)};
                n_match.word = n_match.word | w_word[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= '0;
        end else begin
            r_match <= n_match;
        end
    end

    assign o_last_valid = w_valid[ide_pkg::GROUP_SIZE];
    assign o_match      = r_match;

endmodule

FILE: hdl/instruction_dictionary_encoder.sv
// Top level of the instruction dictionary encoder: control, final merge, count.
// Depends on ide_pkg, ide_group and ide_cell.
//
// A transaction is taken when start is high and busy is low; its result is driven
// on the o_ ports with o_strobe high for exactly one cycle, and it cannot be held
// off by the receiver. busy stays high until the result registers are loaded, so
// a new transaction is not taken while the last one is in flight. The result
// passes the entry compare stage in each cell, the registered merge inside each
// group of sixteen cells, and the final merge across groups into the result
// registers, at whose edge a learned word is written into the next free cell. The
// dictionary holds DICT_DEPTH entries and starts empty after reset, with no
// clearing pass.
module instruction_dictionary_encoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_op,
    input  logic [63:0]                    i_instr_word,
    input  logic [7:0]                     i_entry_index,
    output logic                           o_strobe,
    output logic [7:0]                     o_code,
    output logic                           o_already_present,
    output logic [63:0]                    o_entry_word,
    output logic [8:0]                     o_entry_count,
    output logic [3:0]                     o_code_width,
    output logic [1:0]                     o_status
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_GRP  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]                       r_state;
    logic [1:0]                       n_state;
    ide_pkg::t_key                    r_key;
    logic [ide_pkg::CNT_W-1:0]        r_count;
    logic [ide_pkg::CNT_W-1:0]        n_count;
    ide_pkg::t_wr                     w_wr;
    logic [ide_pkg::NUM_GROUPS:0]     w_gvalid;
    ide_pkg::t_match                  w_gmatch [ide_pkg::NUM_GROUPS];
    ide_pkg::t_match                  w_match;

    logic                             r_strobe;
    logic [7:0]                       r_code;
    logic                             r_present;
    logic [63:0]                      r_entry_word;
    logic [8:0]                       r_entry_count;
    logic [3:0]                       r_code_width;
    logic [1:0]                       r_status;

    logic [7:0]                       n_code;
    logic                             n_present;
    logic [63:0]                      n_entry_word;
    logic [1:0]                       n_status;

    assign w_gvalid[0] = 1'b1;

    for (genvar g = 0; g < ide_pkg::NUM_GROUPS; g++) begin : g_grp
        ide_group u_group (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_prev_valid (w_gvalid[g]),
            .i_wr         (w_wr),
            .i_key        (r_key),
            .i_group      (ide_pkg::GRP_W'(g)),
            .o_last_valid (w_gvalid[g+1]),
            .o_match      (w_gmatch[g])
        );
    end

    always_comb begin
        w_match = '0;
        for (int g = 0; g < ide_pkg::NUM_GROUPS; g++) begin
            w_match.hit  = w_match.hit | w_gmatch[g].hit;
            w_match.idx  = w_match.idx | w_gmatch[g].idx;
            w_match.word = w_match.word | w_gmatch[g].word;
        end
    end

    always_comb begin
        n_code       = '0;
        n_present    = 1'b0;
        n_entry_word = '0;
        n_status     = ide_pkg::ST_OK;
        n_count      = r_count;
        w_wr.en      = 1'b0;
        w_wr.word    = r_key.word;
        unique case (r_key.op)
            ide_pkg::OP_LEARN: begin
                if (w_match.hit) begin
                    n_code    = 8'(w_match.idx);
                    n_present = 1'b1;
                end else if (r_count < ide_pkg::CNT_W'(ide_pkg::DICT_DEPTH)) begin
                    n_code  = 8'(r_count);
                    w_wr.en = (r_state == S_FIN);
                    n_count = r_count + ide_pkg::CNT_W'(1);
                end else begin
                    n_status = ide_pkg::ST_FULL;
                end
            end
            ide_pkg::OP_ENCODE: begin
                if (w_match.hit) begin
                    n_code    = 8'(w_match.idx);
                    n_present = 1'b1;
                end else begin
                    n_status = ide_pkg::ST_MISS;
                end
            end
            ide_pkg::OP_READ: begin
                if (w_match.hit) begin
                    n_code       = 8'(w_match.idx);
                    n_present    = 1'b1;
                    n_entry_word = 64'(w_match.word);
                end else begin
                    n_status = ide_pkg::ST_RANGE;
                end
            end
            default: begin
                n_status = ide_pkg::ST_RANGE;
            end
        endcase
    end

    always_comb begin
        unique case (r_state)
            S_IDLE:  n_state = (start) ? S_CMP : S_IDLE;
            S_CMP:   n_state = S_GRP;
            S_GRP:   n_state = S_FIN;
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == S_FIN);
            if (r_state == S_FIN) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_key.op   <= i_op;
            r_key.word <= i_instr_word[ide_pkg::WORD_WIDTH-1:0];
            r_key.idx  <= i_entry_index;
        end
        if (r_state == S_FIN) begin
            r_code        <= n_code;
            r_present     <= n_present;
            r_entry_word  <= n_entry_word;
            r_entry_count <= 9'(n_count);
            r_code_width  <= ide_pkg::width_for_count(n_count);
            r_status      <= n_status;
        end
    end

    assign busy              = (r_state != S_IDLE);
    assign o_strobe          = r_strobe;
    assign o_code            = r_code;
    assign o_already_present = r_present;
    assign o_entry_word      = r_entry_word;
    assign o_entry_count     = r_entry_count;
    assign o_code_width      = r_code_width;
    assign o_status          = r_status;

    a_done_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_strobe)
        else $error("result strobe missing four cycles after accept");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ide_pkg::CNT_W'(ide_pkg::DICT_DEPTH))
        else $error("entry count beyond dictionary depth");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_FIN) |=> (r_count == $past(r_count)))
        else $error("entry count changed outside final stage");

    a_write_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.en |-> (w_gvalid[ide_pkg::NUM_GROUPS] == 1'b0))
        else $error("insert while every cell is filled");

endmodule

FILE: test/tb_instruction_dictionary_encoder.sv
`timescale 1ns / 1ps
// Testbench for instruction_dictionary_encoder: learn, encode, read and undefined
// transactions checked field by field against a shadow dictionary kept here.
// Depends on ide_pkg and the encoder RTL.
module tb_instruction_dictionary_encoder;

    localparam logic [1:0] OP_UNDEFINED   = 2'd3;
    localparam int         RESULT_LATENCY = 4;
    localparam int         CYCLE_LIMIT    = 200000;

    typedef struct packed {
        logic [7:0]  code;
        logic        present;
        logic [63:0] word;
        logic [8:0]  count;
        logic [3:0]  width;
        logic [1:0]  status;
    } t_dict_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_op;
    logic [63:0] i_instr_word;
    logic [7:0]  i_entry_index;
    logic        o_strobe;
    logic [7:0]  o_code;
    logic        o_already_present;
    logic [63:0] o_entry_word;
    logic [8:0]  o_entry_count;
    logic [3:0]  o_code_width;
    logic [1:0]  o_status;

    logic [63:0]  shadow_words [ide_pkg::DICT_DEPTH];
    int           shadow_count = 0;
    t_dict_result expected_outcomes [$];
    t_dict_result oldest_outcome;
    int           error_count = 0;
    int           cycle_count = 0;
    bit           back_to_back = 1'b0;

    instruction_dictionary_encoder DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_op              (i_op),
        .i_instr_word      (i_instr_word),
        .i_entry_index     (i_entry_index),
        .o_strobe          (o_strobe),
        .o_code            (o_code),
        .o_already_present (o_already_present),
        .o_entry_word      (o_entry_word),
        .o_entry_count     (o_entry_count),
        .o_code_width      (o_code_width),
        .o_status          (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic bit shadow_lookup(input logic [63:0] word, output int pos);
        pos = 0;
        for (int i = 0; i < shadow_count; i++) begin
            if (shadow_words[i] == word) begin
                pos = i;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic [3:0] bits_for_count(input int count);
        int         top;
        logic [3:0] bits;
        top  = (count == 0) ? 0 : count - 1;
        bits = 4'd1;
        while (bits < 9 && (top >> bits) != 0) begin
            bits++;
        end
        return bits;
    endfunction

    function automatic t_dict_result dictionary_outcome(input logic [1:0] op,
                                                        input logic [63:0] word,
                                                        input logic [7:0] index);
        t_dict_result r;
        int           pos;
        r = '0;
        case (op)
            ide_pkg::OP_LEARN: begin
                if (shadow_lookup(word, pos)) begin
                    r.code    = 8'(pos);
                    r.present = 1'b1;
                end else if (shadow_count < ide_pkg::DICT_DEPTH) begin
                    shadow_words[shadow_count] = word;
                    r.code = 8'(shadow_count);
                    shadow_count++;
                end else begin
                    r.status = ide_pkg::ST_FULL;
                end
            end
            ide_pkg::OP_ENCODE: begin
                if (shadow_lookup(word, pos)) begin
                    r.code    = 8'(pos);
                    r.present = 1'b1;
                end else begin
                    r.status = ide_pkg::ST_MISS;
                end
            end
            ide_pkg::OP_READ: begin
                if (int'(index) < shadow_count) begin
                    r.code    = index;
                    r.present = 1'b1;
                    r.word    = shadow_words[index];
                end else begin
                    r.status = ide_pkg::ST_RANGE;
                end
            end
            default: begin
                r.status = ide_pkg::ST_RANGE;
            end
        endcase
        r.count = 9'(shadow_count);
        r.width = bits_for_count(shadow_count);
        return r;
    endfunction

    task automatic report_field(input string field, input logic [63:0] expected,
                                input logic [63:0] actual);
        if (actual !== expected) begin
            $error("%s: expected %0h, actual %0h", field, expected, actual);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (expected_outcomes.size() == 0) begin
                $error("result with no transaction outstanding");
                error_count++;
            end else begin
                oldest_outcome = expected_outcomes.pop_front();
                report_field("code", 64'(oldest_outcome.code), 64'(o_code));
                report_field("already_present", 64'(oldest_outcome.present),
                             64'(o_already_present));
                report_field("entry_word", oldest_outcome.word, o_entry_word);
                report_field("entry_count", 64'(oldest_outcome.count),
                             64'(o_entry_count));
                report_field("code_width", 64'(oldest_outcome.width),
                             64'(o_code_width));
                report_field("status", 64'(oldest_outcome.status), 64'(o_status));
            end
        end
    end

    task automatic send_transaction(input logic [1:0] op, input logic [63:0] word,
                                    input logic [7:0] index);
        int gap;
        gap = back_to_back ? 0 : $urandom_range(0, 5);
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start         <= 1'b1;
        i_op          <= op;
        i_instr_word  <= word;
        i_entry_index <= index;
        do @(posedge i_clk); while (busy);
        expected_outcomes.push_back(dictionary_outcome(op, word, index));
    endtask

    task automatic drain_outstanding();
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_outcomes.size() != 0) @(posedge i_clk);
        repeat (RESULT_LATENCY + 2) @(posedge i_clk);
    endtask

    function automatic logic [63:0] random_word();
        case ($urandom_range(0, 3))
            0:       return {$urandom, $urandom};
            1:       return 64'd1 << $urandom_range(0, 63);
            2:       return 64'($urandom_range(0, 15));
            default: return ~(64'd1 << $urandom_range(0, 63));
        endcase
    endfunction

    function automatic logic [63:0] stored_word();
        if (shadow_count == 0) begin
            return random_word();
        end
        return shadow_words[$urandom_range(0, shadow_count - 1)];
    endfunction

    task automatic random_transaction();
        int          pick;
        logic [63:0] word;
        logic [7:0]  index;
        pick  = $urandom_range(0, 99);
        word  = random_word();
        index = 8'($urandom);
        if (pick < 30) begin
            send_transaction(ide_pkg::OP_LEARN, word, index);
        end else if (pick < 45) begin
            send_transaction(ide_pkg::OP_LEARN, stored_word(), index);
        end else if (pick < 65) begin
            send_transaction(ide_pkg::OP_ENCODE, stored_word(), index);
        end else if (pick < 80) begin
            send_transaction(ide_pkg::OP_ENCODE,
                             stored_word() ^ (64'd1 << $urandom_range(0, 63)), index);
        end else if (pick < 95) begin
            if (shadow_count > 0 && $urandom_range(0, 1) == 1) begin
                index = 8'($urandom_range(0, shadow_count - 1));
            end
            send_transaction(ide_pkg::OP_READ, word, index);
        end else begin
            send_transaction(OP_UNDEFINED, word, index);
        end
    endtask

    task automatic test_empty_dictionary();
        send_transaction(ide_pkg::OP_READ, 64'd0, 8'd0);
        send_transaction(ide_pkg::OP_READ, '1, 8'hff);
        send_transaction(ide_pkg::OP_ENCODE, '1, 8'd0);
        send_transaction(ide_pkg::OP_ENCODE, 64'd0, 8'hff);
        send_transaction(OP_UNDEFINED, '1, 8'hff);
    endtask

    task automatic test_first_entries();
        send_transaction(ide_pkg::OP_LEARN, 64'd0, 8'd0);
        send_transaction(ide_pkg::OP_LEARN, '1, 8'hff);
        send_transaction(ide_pkg::OP_LEARN, 64'd0, 8'd0);
        send_transaction(ide_pkg::OP_ENCODE, '1, 8'd0);
        send_transaction(ide_pkg::OP_ENCODE, 64'h8000_0000_0000_0000, 8'd0);
        send_transaction(ide_pkg::OP_LEARN, 64'h8000_0000_0000_0000, 8'd0);
        send_transaction(ide_pkg::OP_READ, 64'd0, 8'd0);
        send_transaction(ide_pkg::OP_READ, 64'd0, 8'd2);
        send_transaction(ide_pkg::OP_READ, 64'd0, 8'd3);
        send_transaction(ide_pkg::OP_READ, '1, 8'hff);
        send_transaction(OP_UNDEFINED, 64'd0, 8'd0);
    endtask

    task automatic test_random_traffic(input int items);
        for (int n = 0; n < items; n++) begin
            if (n % 40 == 0) begin
                back_to_back = ($urandom_range(0, 3) == 0);
            end
            random_transaction();
        end
        back_to_back = 1'b0;
    endtask

    task automatic test_fill_table();
        int          pos;
        logic [63:0] word;
        while (shadow_count < ide_pkg::DICT_DEPTH) begin
            word = ($urandom_range(0, 1) == 1) ? {$urandom, $urandom} : random_word();
            if (!shadow_lookup(word, pos)) begin
                send_transaction(ide_pkg::OP_LEARN, word, 8'($urandom));
            end
        end
    endtask

    task automatic test_full_table();
        int          pos;
        logic [63:0] word;
        word = {$urandom, $urandom};
        while (shadow_lookup(word, pos)) word = {$urandom, $urandom};
        send_transaction(ide_pkg::OP_LEARN, word, 8'd0);
        send_transaction(ide_pkg::OP_LEARN, shadow_words[ide_pkg::DICT_DEPTH - 1], 8'd0);
        send_transaction(ide_pkg::OP_ENCODE, shadow_words[ide_pkg::DICT_DEPTH - 1], 8'd0);
        send_transaction(ide_pkg::OP_ENCODE, word, 8'd0);
        send_transaction(ide_pkg::OP_READ, 64'd0, 8'hff);
        send_transaction(ide_pkg::OP_READ, '1, 8'd0);
        send_transaction(ide_pkg::OP_LEARN, '1, 8'hff);
        send_transaction(OP_UNDEFINED, word, 8'h80);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_op          = ide_pkg::OP_LEARN;
        i_instr_word  = 64'd0;
        i_entry_index = 8'd0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_dictionary();
        test_first_entries();
        test_random_traffic(700);
        drain_outstanding();
        test_fill_table();
        test_full_table();
        test_random_traffic(900);
        drain_outstanding();

        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
